>>> rtl/seng_pkg.sv
// Shared types and constants for the stack engine.
`timescale 1ns / 1ps
`default_nettype none

package seng_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_MOD   = 3'd1,
    REQ_PCHAR = 3'd2,
    REQ_PSTR  = 3'd3,
    REQ_ROTL  = 3'd4,
    REQ_ROTR  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_DIV_ZERO  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOD_B,
    S_MOD_A,
    S_MOD_DIV,
    S_PCHAR_RD,
    S_PCHAR_EMIT,
    S_PSTR_CHK,
    S_PSTR_RD,
    S_PSTR_EMIT,
    S_ROTL_WR,
    S_ROTR_WR,
    S_NEWLINE,
    S_STATUS
  } state_t;

  localparam int          PRINT_LIMIT   = 32;
  localparam int          KW            = $clog2(PRINT_LIMIT + 1);
  localparam logic [6:0]  NEWLINE_CODE  = 7'd10;

endpackage

`default_nettype wire

>>> rtl/seng_rem.sv
// Iterative restoring remainder unit with C-style truncating sign rules.
`timescale 1ns / 1ps
`default_nettype none

module seng_rem #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      remainder
);

  localparam int W    = VALUE_WIDTH;
  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    ub;
  logic            neg;
  logic [W:0]      r_sh;
  logic [W:0]      diff;
  logic [W-1:0]    rem_next;

  always_comb begin
    r_sh = {rem, quo[W-1]};
    diff = r_sh - {1'b0, ub};
    if (!diff[W]) begin
      rem_next = diff[W-1:0];
    end else begin
      rem_next = r_sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
      ub  <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
      neg <= dividend[W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[W-2:0], 1'b0};
      if (cnt == CNTW'(1)) begin
        remainder <= neg ? (~rem_next + W'(1)) : rem_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/stack_engine_mod_rotate_print_core.sv
// Top level of the stack engine: ring deque in a synchronous memory and its sequencer.
// Push, rotate and error requests each give a single status result; mod waits on the
// remainder unit, which computes one bit per cycle. Print string runs check, read and emit
// states per character on the one memory read port, then emits a newline; print char emits
// one character and a newline. A new request is taken once the last result is loaded.
// Reset clears the element count, bottom index and sequencer; stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stack_engine_mod_rotate_print_core #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [2:0]         req_type,
  input  wire logic signed [31:0] push_value,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic [2:0]              status,
  output logic                    char_valid,
  output logic [6:0]              char_out,
  output logic                    last
);

  import seng_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] bottom, bottom_next;
  logic [CW-1:0] walk, walk_next;
  logic [KW-1:0] nchars, nchars_next;
  logic [2:0]    req, req_next;
  logic [W-1:0]  val, val_next;
  logic [W-1:0]  opb, opb_next;
  logic [6:0]    chr, chr_next;
  logic [2:0]    st_code, st_code_next;

  logic          load;
  logic [2:0]    ld_status;
  logic          ld_char_valid;
  logic [6:0]    ld_char;
  logic          ld_last;
  logic          out_free;
  logic [63:0]   push_ext;
  logic [AW-1:0] bot_dec;
  logic [AW-1:0] bot_inc;
  logic          rd_in_range;

  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_rem;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(STACK_DEPTH)) begin
      sum = sum - SW'(STACK_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  seng_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rdata),
    .divisor   (opb),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  assign out_free    = !res_valid || res_ready;
  assign req_ready   = (state == S_IDLE);
  assign push_ext    = {{32{push_value[31]}}, push_value};
  assign bot_dec     = (bottom == '0) ? AW'(STACK_DEPTH - 1) : bottom - AW'(1);
  assign bot_inc     = (bottom == AW'(STACK_DEPTH - 1)) ? '0 : bottom + AW'(1);
  assign rd_in_range = (rdata[W-1:7] == '0);

  always_comb begin
    state_next    = state;
    count_next    = count;
    bottom_next   = bottom;
    walk_next     = walk;
    nchars_next   = nchars;
    req_next      = req;
    val_next      = val;
    opb_next      = opb;
    chr_next      = chr;
    st_code_next  = st_code;
    raddr         = slot(bottom, count - CW'(1));
    mem_we        = 1'b0;
    mem_waddr     = slot(bottom, count);
    mem_wdata     = val;
    div_start     = 1'b0;
    load          = 1'b0;
    ld_status     = ST_OK;
    ld_char_valid = 1'b0;
    ld_char       = '0;
    ld_last       = 1'b1;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_next   = req_type;
          val_next   = push_ext[W-1:0];
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        st_code_next = ST_OK;
        state_next   = S_STATUS;
        case (req)
          REQ_PUSH: begin
            if (count == CW'(STACK_DEPTH)) begin
              st_code_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          REQ_MOD: begin
            if (count < CW'(2)) begin
              st_code_next = ST_TOO_SHORT;
            end else begin
              state_next = S_MOD_B;
            end
          end
          REQ_PCHAR: begin
            if (count == '0) begin
              st_code_next = ST_TOO_SHORT;
            end else begin
              state_next = S_PCHAR_RD;
            end
          end
          REQ_PSTR: begin
            walk_next   = count;
            nchars_next = '0;
            state_next  = S_PSTR_CHK;
          end
          REQ_ROTL: begin
            if (count >= CW'(2)) begin
              state_next = S_ROTL_WR;
            end
          end
          REQ_ROTR: begin
            raddr = bottom;
            if (count >= CW'(2)) begin
              state_next = S_ROTR_WR;
            end
          end
          default: begin
            st_code_next = ST_OK;
          end
        endcase
      end
      S_MOD_B: begin
        opb_next   = rdata;
        raddr      = slot(bottom, count - CW'(2));
        state_next = S_MOD_A;
      end
      S_MOD_A: begin
        if (opb == '0) begin
          st_code_next = ST_DIV_ZERO;
          state_next   = S_STATUS;
        end else begin
          div_start  = 1'b1;
          state_next = S_MOD_DIV;
        end
      end
      S_MOD_DIV: begin
        if (div_done) begin
          mem_we       = 1'b1;
          mem_waddr    = slot(bottom, count - CW'(2));
          mem_wdata    = div_rem;
          count_next   = count - CW'(1);
          st_code_next = ST_OK;
          state_next   = S_STATUS;
        end
      end
      S_PCHAR_RD: begin
        chr_next = rdata[6:0];
        if (rd_in_range) begin
          state_next = S_PCHAR_EMIT;
        end else begin
          st_code_next = ST_RANGE;
          state_next   = S_STATUS;
        end
      end
      S_PCHAR_EMIT: begin
        if (out_free) begin
          load          = 1'b1;
          ld_char_valid = 1'b1;
          ld_char       = chr;
          ld_last       = 1'b0;
          state_next    = S_NEWLINE;
        end
      end
      S_PSTR_CHK: begin
        raddr = slot(bottom, walk - CW'(1));
        if (walk == '0 || nchars == KW'(PRINT_LIMIT)) begin
          state_next = S_NEWLINE;
        end else begin
          state_next = S_PSTR_RD;
        end
      end
      S_PSTR_RD: begin
        chr_next = rdata[6:0];
        if (rd_in_range && rdata != '0) begin
          state_next = S_PSTR_EMIT;
        end else begin
          state_next = S_NEWLINE;
        end
      end
      S_PSTR_EMIT: begin
        if (out_free) begin
          load          = 1'b1;
          ld_char_valid = 1'b1;
          ld_char       = chr;
          ld_last       = 1'b0;
          walk_next     = walk - CW'(1);
          nchars_next   = nchars + KW'(1);
          state_next    = S_PSTR_CHK;
        end
      end
      S_ROTL_WR: begin
        mem_we      = 1'b1;
        mem_waddr   = bot_dec;
        mem_wdata   = rdata;
        bottom_next = bot_dec;
        state_next  = S_STATUS;
      end
      S_ROTR_WR: begin
        mem_we      = 1'b1;
        mem_waddr   = slot(bot_inc, count - CW'(1));
        mem_wdata   = rdata;
        bottom_next = bot_inc;
        state_next  = S_STATUS;
      end
      S_NEWLINE: begin
        if (out_free) begin
          load          = 1'b1;
          ld_char_valid = 1'b1;
          ld_char       = NEWLINE_CODE;
          state_next    = S_IDLE;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          load       = 1'b1;
          ld_status  = st_code;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      bottom    <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      bottom <= bottom_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk    <= walk_next;
    nchars  <= nchars_next;
    req     <= req_next;
    val     <= val_next;
    opb     <= opb_next;
    chr     <= chr_next;
    st_code <= st_code_next;
    if (load) begin
      status     <= ld_status;
      char_valid <= ld_char_valid;
      char_out   <= ld_char;
      last       <= ld_last;
    end
  end

endmodule

`default_nettype wire
